>>> design/assert_macros.svh
// Assertion macros used by the port-level checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk_sig, rst_n, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// Consequent that must hold on the edge after the antecedent, outside reset.
`define ASSERT_NEXT(lbl, clk_sig, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> design/aes_pkg.sv
// Package for the AES block cipher: payload types, S-box functions, helpers.
// No dependencies.
package aes_pkg;
	typedef struct packed {
		logic        op;
		logic [63:0] block_hi;
		logic [63:0] block_lo;
	} in_t;

	typedef struct packed {
		logic [63:0] result_hi;
		logic [63:0] result_lo;
	} out_t;

	localparam int KeyDepth = 60;
	localparam int KeyAw = 6;
	localparam logic OpEnc = 1'b0;
	localparam logic OpDec = 1'b1;

	localparam logic [2:0] RegKeyLen = 3'd0;
	localparam logic [2:0] RegKey0 = 3'd1;
	localparam logic [2:0] RegKey1 = 3'd2;
	localparam logic [2:0] RegKey2 = 3'd3;
	localparam logic [2:0] RegKey3 = 3'd4;

	typedef logic [7:0] sbox_t [256];

	localparam sbox_t SBOX = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	localparam sbox_t ISBOX = '{
	8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
	8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
	8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
	8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
	8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
	8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
	8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
	8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
	8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
	8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
	8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
	8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
	8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
	8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
	8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
	8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction
endpackage

>>> design/aes_block_cipher.sv
// Top level of the AES block cipher: register port, key expansion, round sequencer.
// Depends on aes_pkg, aes_key_mem and aes_round.
//
// Usage: write key_length and key_bits_0..3 over the APB port while idle.
// Before the first block after any key write, the key schedule is expanded
// into the round key store, one word per cycle (44, 52 or 60 words).
// Input transactions carry op and a 16-byte block; one result transaction
// follows per input. A block takes Nr+1 round steps; each step reads four key
// words, one per cycle from the single read port of the store, waits for the
// registered last word and then applies the round. out_valid rises once the
// last step is done and the result is moved to the output register; a new
// input is accepted only after the previous block has left the round state,
// and the expansion runs first when the schedule is stale.
// in_stall is high while a block is being processed. A result is held in the
// output register with out_valid high until the receiver lowers out_stall;
// the next block may be accepted meanwhile, but its result waits in the round
// state, with in_stall high, until the output register is free.
// Reset clears the key and control registers to zero, drops all valid flags
// and marks the schedule stale, so the first block expands an all-zero 128-bit key.
module aes_block_cipher (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [5:0]     paddr,
	input  logic [63:0]    pwdata,
	output logic [63:0]    prdata,
	output logic           pready,
	input  logic           in_valid,
	output logic           in_stall,
	input  aes_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output aes_pkg::out_t  out_data
);
	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StExp  = 3'd1;
	localparam logic [2:0] StRd   = 3'd2;
	localparam logic [2:0] StRnd  = 3'd3;
	localparam logic [2:0] StOut  = 3'd4;

	logic [2:0]  st_q;
	logic [1:0]  klen_q;
	logic [63:0] key_q [4];
	logic        ready_q;
	logic [5:0]  widx_q;
	logic [5:0]  total;
	logic [3:0]  nk;
	logic [31:0] prev_q;
	logic [31:0] win_q [8];
	logic [3:0]  nr;
	logic [1:0]  col_q;
	logic        rvalid_q;
	logic [1:0]  rcol_q;
	logic [127:0] rk_q;
	logic [127:0] st128_q;
	logic        dec_q;
	logic [3:0]  step_q;
	logic        we;
	logic [5:0]  waddr;
	logic [31:0] wdata;
	logic [5:0]  raddr;
	logic [31:0] rdata;
	logic [127:0] rnext;
	logic        wr;
	logic [2:0]  ridx;
	logic [3:0]  kpos;
	logic [31:0] t;
	logic [31:0] key_word;
	logic [7:0]  rc;
	logic [3:0]  rkno;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign ridx = paddr[5:3];
	assign nk = (klen_q == 2'd0) ? 4'd4 : ((klen_q == 2'd1) ? 4'd6 : 4'd8);
	assign nr = nk + 4'd6;
	assign total = 6'((nr + 4'd1) * 3'd4);

	always_comb begin
		unique case (ridx)
			aes_pkg::RegKeyLen: prdata = {62'd0, klen_q};
			aes_pkg::RegKey0:   prdata = key_q[0];
			aes_pkg::RegKey1:   prdata = key_q[1];
			aes_pkg::RegKey2:   prdata = key_q[2];
			aes_pkg::RegKey3:   prdata = key_q[3];
			default:            prdata = 64'd0;
		endcase
	end

	// Key expansion: position within the current key-length period and rcon.
	always_comb begin
		kpos = 4'd0;
		rc = 8'h01;
		for (int j = 1; j <= 10; j++) begin
			if ({1'b0, widx_q} >= 7'(nk) * 7'(j)) begin
				kpos = 4'({1'b0, widx_q} - 7'(nk) * 7'(j));
				rc = (j == 9) ? 8'h1b : ((j == 10) ? 8'h36 : 8'(8'h01 << (j - 1)));
			end
		end
		if (widx_q < 6'(nk)) begin
			kpos = widx_q[3:0];
		end
		key_word = widx_q[0] ? key_q[widx_q[2:1]][31:0] : key_q[widx_q[2:1]][63:32];
		t = prev_q;
		if (kpos == 4'd0) begin
			t = aes_pkg::sub_word({prev_q[23:0], prev_q[31:24]}) ^ {rc, 24'd0};
		end else if (nk == 4'd8 && kpos == 4'd4) begin
			t = aes_pkg::sub_word(prev_q);
		end
		wdata = (widx_q < 6'(nk)) ? key_word : (win_q[3'(nk - 4'd1)] ^ t);
	end

	// rc above is the rcon for the period that widx lies in; period 1 uses 0x01.
	assign we = (st_q == StExp);
	assign waddr = widx_q;
	assign rkno = dec_q ? 4'(nr - step_q) : step_q;
	assign raddr = 6'({rkno, col_q});

	aes_key_mem u_mem (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	aes_round u_round (
		.dec  (dec_q),
		.first(step_q == 4'd0),
		.last (step_q == nr),
		.state(st128_q),
		.rkey (rk_q),
		.next (rnext)
	);

	assign in_stall = (st_q != StIdle);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= StIdle;
			klen_q <= 2'd0;
			for (int i = 0; i < 4; i++) key_q[i] <= 64'd0;
			ready_q <= 1'b0;
			widx_q <= 6'd0;
			col_q <= 2'd0;
			rvalid_q <= 1'b0;
			step_q <= 4'd0;
			out_valid <= 1'b0;
		end else begin
			if (wr) begin
				priority if (ridx == aes_pkg::RegKeyLen) begin
					klen_q <= (pwdata[1:0] == 2'd3) ? 2'd2 : pwdata[1:0];
					ready_q <= 1'b0;
				end else if (ridx <= aes_pkg::RegKey3) begin
					key_q[2'(ridx - 3'd1)] <= pwdata;
					ready_q <= 1'b0;
				end
			end
			if (out_valid && !out_stall && st_q != StOut) begin
				out_valid <= 1'b0;
			end
			rvalid_q <= 1'b0;
			unique case (st_q)
				StIdle: begin
					if (in_valid) begin
						step_q <= 4'd0;
						col_q <= 2'd0;
						widx_q <= 6'd0;
						st_q <= ready_q ? StRd : StExp;
					end
				end
				StExp: begin
					widx_q <= widx_q + 6'd1;
					if (widx_q == total - 6'd1) begin
						ready_q <= 1'b1;
						st_q <= StRd;
					end
				end
				StRd: begin
					col_q <= col_q + 2'd1;
					rvalid_q <= 1'b1;
					if (col_q == 2'd3) st_q <= StRnd;
				end
				StRnd: begin
					if (!rvalid_q) begin
						step_q <= step_q + 4'd1;
						if (step_q == nr) begin
							st_q <= StOut;
						end else begin
							st_q <= StRd;
						end
					end
				end
				StOut: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						st_q <= StIdle;
					end
				end
				default: st_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == StIdle && in_valid) begin
			dec_q <= in_data.op;
			st128_q <= {in_data.block_hi, in_data.block_lo};
		end
		if (st_q == StExp) begin
			prev_q <= wdata;
			win_q[0] <= wdata;
			for (int i = 1; i < 8; i++) win_q[i] <= win_q[i-1];
		end
		rcol_q <= col_q;
		if (rvalid_q) begin
			rk_q[127-32*rcol_q -: 32] <= rdata;
		end
		if (st_q == StRnd && !rvalid_q) begin
			st128_q <= rnext;
		end
		if (st_q == StOut && (!out_valid || !out_stall)) begin
			out_data <= {st128_q[127:64], st128_q[63:0]};
		end
	end
endmodule

>>> design/aes_key_mem.sv
// Round key store: 60 words of 32 bits, one write and one registered read port.
// Depends on aes_pkg.
module aes_key_mem (
	input  logic                       clk,
	input  logic                       we,
	input  logic [aes_pkg::KeyAw-1:0]  waddr,
	input  logic [31:0]                wdata,
	input  logic [aes_pkg::KeyAw-1:0]  raddr,
	output logic [31:0]                rdata
);
	logic [31:0] mem_q [aes_pkg::KeyDepth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> design/aes_round.sv
// One AES round, forward or inverse, as combinational logic.
// Depends on aes_pkg.
module aes_round (
	input  logic         dec,
	input  logic         first,
	input  logic         last,
	input  logic [127:0] state,
	input  logic [127:0] rkey,
	output logic [127:0] next
);
	function automatic logic [7:0] xt(input logic [7:0] b);
		xt = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	logic [7:0] s [16];
	logic [7:0] t [16];
	logic [7:0] u [16];
	logic [7:0] m [16];
	logic [7:0] k [16];
	logic [7:0] a0, a1, a2, a3, b0, b1, b2, b3, c0, c1, c2, c3;

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			s[i] = state[127-8*i -: 8];
			k[i] = rkey[127-8*i -: 8];
		end
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				if (dec) begin
					t[r+4*((c+r)%4)] = aes_pkg::ISBOX[s[r+4*c]];
				end else begin
					t[r+4*c] = aes_pkg::SBOX[s[r+4*((c+r)%4)]];
				end
			end
		end
		for (int i = 0; i < 16; i++) begin
			u[i] = first ? s[i] ^ k[i] : ((dec || last) ? t[i] ^ k[i] : t[i]);
		end
		for (int c = 0; c < 4; c++) begin
			a0 = u[4*c]; a1 = u[4*c+1]; a2 = u[4*c+2]; a3 = u[4*c+3];
			b0 = xt(a0); b1 = xt(a1); b2 = xt(a2); b3 = xt(a3);
			c0 = xt(b0); c1 = xt(b1); c2 = xt(b2); c3 = xt(b3);
			if (dec) begin
				// Multiply by {05,00,04,00} first, then apply the forward matrix.
				a0 = u[4*c] ^ c0 ^ c2;
				a1 = u[4*c+1] ^ c1 ^ c3;
				a2 = u[4*c+2] ^ c0 ^ c2;
				a3 = u[4*c+3] ^ c1 ^ c3;
				b0 = xt(a0); b1 = xt(a1); b2 = xt(a2); b3 = xt(a3);
			end
			m[4*c]   = b0 ^ b1 ^ a1 ^ a2 ^ a3;
			m[4*c+1] = a0 ^ b1 ^ b2 ^ a2 ^ a3;
			m[4*c+2] = a0 ^ a1 ^ b2 ^ b3 ^ a3;
			m[4*c+3] = b0 ^ a0 ^ a1 ^ a2 ^ b3;
		end
		for (int i = 0; i < 16; i++) begin
			if (first || last) begin
				next[127-8*i -: 8] = u[i];
			end else if (dec) begin
				next[127-8*i -: 8] = m[i];
			end else begin
				next[127-8*i -: 8] = m[i] ^ k[i];
			end
		end
	end
endmodule

>>> design/aes_block_cipher_chk.sv
// Port-level checker for the AES block cipher, bound to the top level.
// Depends on assert_macros.svh and aes_block_cipher.
`include "assert_macros.svh"
module aes_block_cipher_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic pready
);
	`ASSERT_CLK(a_pready, clk, arst_n, pready)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`ASSERT_NEXT(a_busy_after_in, clk, arst_n, in_valid && !in_stall, in_stall)
	`ASSERT_NEXT(a_no_early_out, clk, arst_n, in_valid && !in_stall, !$rose(out_valid))
endmodule

bind aes_block_cipher aes_block_cipher_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .pready(pready)
);

>>> tb/aes_block_cipher_checker.sv
// Checker for the AES block cipher: watches both channels, predicts each result and compares.
// Depends on aes_pkg; the stimulus side reports key register writes to it.
`timescale 1ns / 1ps
module aes_block_cipher_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_stall,
	input  aes_pkg::in_t   in_data,
	input  logic           out_valid,
	input  logic           out_stall,
	input  aes_pkg::out_t  out_data,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_idx,
	input  logic [63:0]    cfg_val,
	output int             fail_count,
	output int             pending
);
	localparam logic [7:0] SbTab [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	logic [63:0]   key_regs [5];
	logic [31:0]   sched [60];
	bit            sched_fresh;
	aes_pkg::out_t expected_blocks [$];
	logic [7:0]    inv_tab [256];

	initial begin
		for (int k = 0; k < 256; k++) inv_tab[SbTab[k]] = 8'(k);
	end

	function automatic logic [7:0] sb(input logic [7:0] b);
		return SbTab[b];
	endfunction

	function automatic logic [7:0] inv_sb(input logic [7:0] b);
		return inv_tab[b];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] b, input int m);
		logic [7:0] acc;
		acc = 8'h00;
		while (m != 0) begin
			if (m[0]) acc ^= b;
			b = xtime(b);
			m = m >> 1;
		end
		return acc;
	endfunction

	function automatic int key_words();
		int k;
		k = key_regs[0][1:0];
		if (k > 2) k = 2;
		return 4 + 2 * k;
	endfunction

	task automatic build_schedule();
		int nk;
		int i;
		logic [31:0] t;
		logic [7:0] rc;
		nk = key_words();
		for (i = 0; i < nk; i++)
			sched[i] = i[0] ? key_regs[1 + i / 2][31:0] : key_regs[1 + i / 2][63:32];
		for (i = nk; i < 4 * (nk + 7); i++) begin
			t = sched[i - 1];
			if (i % nk == 0) begin
				t = {t[23:0], t[31:24]};
				t = {sb(t[31:24]), sb(t[23:16]), sb(t[15:8]), sb(t[7:0])};
				rc = 8'h01;
				repeat ((i / nk - 1) % 10) rc = xtime(rc);
				t ^= {rc, 24'h0};
			end else if (nk > 6 && i % nk == 4) begin
				t = {sb(t[31:24]), sb(t[23:16]), sb(t[15:8]), sb(t[7:0])};
			end
			sched[i] = sched[i - nk] ^ t;
		end
		sched_fresh = 1;
	endtask

	function automatic aes_pkg::out_t cipher_block(input aes_pkg::in_t item);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] col [4];
		logic [7:0] acc;
		logic [31:0] w;
		int fwd [4];
		int inv [4];
		int nr, r, i, c, k, d, rr;
		aes_pkg::out_t res;
		fwd = '{2, 3, 1, 1};
		inv = '{14, 11, 13, 9};
		nr = key_words() + 6;
		for (i = 0; i < 8; i++) begin
			s[i] = item.block_hi[63 - 8 * i -: 8];
			s[8 + i] = item.block_lo[63 - 8 * i -: 8];
		end
		for (rr = 0; rr <= nr; rr++) begin
			r = (item.op == aes_pkg::OpEnc) ? rr : nr - rr;
			if (rr > 0) begin
				if (item.op == aes_pkg::OpEnc) begin
					for (i = 0; i < 16; i++) s[i] = sb(s[i]);
					for (i = 0; i < 4; i++)
						for (c = 0; c < 4; c++) t[i + 4 * c] = s[i + 4 * ((c + i) % 4)];
					s = t;
					if (rr < nr) begin
						for (c = 0; c < 4; c++) begin
							for (k = 0; k < 4; k++) col[k] = s[4 * c + k];
							for (i = 0; i < 4; i++) begin
								acc = 8'h00;
								for (k = 0; k < 4; k++) acc ^= gf_mul(col[k], fwd[(k + 4 - i) % 4]);
								s[4 * c + i] = acc;
							end
						end
					end
				end else begin
					for (i = 0; i < 4; i++)
						for (c = 0; c < 4; c++) begin
							d = i + 4 * ((c + i) % 4);
							t[d] = s[i + 4 * c];
						end
					s = t;
					for (i = 0; i < 16; i++) s[i] = inv_sb(s[i]);
				end
			end
			for (c = 0; c < 4; c++) begin
				w = sched[(4 * r + c) % 60];
				for (k = 0; k < 4; k++) s[4 * c + k] ^= w[31 - 8 * k -: 8];
			end
			if (item.op == aes_pkg::OpDec && rr > 0 && r > 0) begin
				for (c = 0; c < 4; c++) begin
					for (k = 0; k < 4; k++) col[k] = s[4 * c + k];
					for (i = 0; i < 4; i++) begin
						acc = 8'h00;
						for (k = 0; k < 4; k++) acc ^= gf_mul(col[k], inv[(k + 4 - i) % 4]);
						s[4 * c + i] = acc;
					end
				end
			end
		end
		for (i = 0; i < 8; i++) begin
			res.result_hi[63 - 8 * i -: 8] = s[i];
			res.result_lo[63 - 8 * i -: 8] = s[8 + i];
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		aes_pkg::out_t want;
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) key_regs[i] = '0;
			sched_fresh = 0;
			fail_count = 0;
			expected_blocks.delete();
		end else begin
			if (cfg_we && cfg_idx <= aes_pkg::RegKey3) begin
				key_regs[cfg_idx] = (cfg_idx == aes_pkg::RegKeyLen) ?
					{62'h0, cfg_val[1:0]} : cfg_val;
				sched_fresh = 0;
			end
			if (in_valid && !in_stall) begin
				if (!sched_fresh) build_schedule();
				expected_blocks = {expected_blocks, cipher_block(in_data)};
			end
			if (out_valid && !out_stall) begin
				if (expected_blocks.size() == 0) begin
					$display("%0t: unexpected result %h", $time, out_data);
					fail_count++;
				end else begin
					want = expected_blocks.pop_front();
					if (want.result_hi !== out_data.result_hi) begin
						$display("%0t: result_hi expected %h actual %h", $time,
							want.result_hi, out_data.result_hi);
						fail_count++;
					end
					if (want.result_lo !== out_data.result_lo) begin
						$display("%0t: result_lo expected %h actual %h", $time,
							want.result_lo, out_data.result_lo);
						fail_count++;
					end
				end
			end
		end
		pending = expected_blocks.size();
	end
endmodule

>>> tb/tb_aes_block_cipher.sv
// Testbench top for the AES block cipher: clock, reset, key writes, block stimulus and verdict.
// Depends on aes_pkg, aes_block_cipher and aes_block_cipher_checker.
`timescale 1ns / 1ps
module tb_aes_block_cipher;
	logic          clk = 0;
	logic          arst_n = 0;
	logic          psel = 0, penable = 0, pwrite = 0;
	logic [5:0]    paddr = '0;
	logic [63:0]   pwdata = '0;
	logic [63:0]   prdata;
	logic          pready;
	logic          in_valid = 0;
	logic          in_stall;
	aes_pkg::in_t  in_data = '0;
	logic          out_valid;
	logic          out_stall = 0;
	aes_pkg::out_t out_data;
	int            fail_count, pending;
	int            idle_cycles = 0;
	bit            long_hold = 0;

	always #1 clk = ~clk;

	aes_block_cipher dut (.*);

	aes_block_cipher_checker chk (
		.clk, .arst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
		.cfg_we(psel && penable && pwrite && pready), .cfg_idx(paddr[5:3]), .cfg_val(pwdata),
		.fail_count, .pending
	);

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(negedge clk);
		psel <= 1; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic send_block(input logic op, input logic [63:0] hi, input logic [63:0] lo);
		in_valid <= 1;
		in_data <= '{op: op, block_hi: hi, block_lo: lo};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic set_key(input logic [1:0] klen);
		write_reg(aes_pkg::RegKeyLen, {62'h0, klen});
		write_reg(aes_pkg::RegKey0, rand64());
		write_reg(aes_pkg::RegKey1, rand64());
		write_reg(aes_pkg::RegKey2, rand64());
		write_reg(aes_pkg::RegKey3, rand64());
	endtask

	always @(negedge clk) begin
		if (!long_hold) out_stall <= ($urandom_range(0, 3) == 0) && ($time % 2000 > 600);
		else out_stall <= 1;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int phase, n, burst, nb;
		logic [63:0] k [4];
		repeat (9) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// Blocks before any key write use the all-zero 128-bit key.
		send_block(aes_pkg::OpEnc, '0, '0);
		send_block(aes_pkg::OpDec, '1, '1);
		in_valid <= 0;
		drain();
		// Known-answer keys from the standard, all three lengths.
		k = '{64'h0001020304050607, 64'h08090a0b0c0d0e0f,
			64'h1011121314151617, 64'h18191a1b1c1d1e1f};
		for (int kl = 0; kl < 4; kl++) begin
			write_reg(aes_pkg::RegKeyLen, 64'(kl));
			for (int j = 0; j < 4; j++) write_reg(aes_pkg::RegKey0 + 3'(j), k[j]);
			send_block(aes_pkg::OpEnc, 64'h0011223344556677, 64'h8899aabbccddeeff);
			send_block(aes_pkg::OpDec, 64'h0011223344556677, 64'h8899aabbccddeeff);
			send_block(aes_pkg::OpEnc, '1, '0);
			send_block(aes_pkg::OpDec, '0, '1);
			in_valid <= 0;
			drain();
		end
		// Long hold-off on the receiver while blocks keep being offered.
		fork
			begin
				long_hold = 1;
				repeat (400) @(negedge clk);
				long_hold = 0;
			end
			for (int j = 0; j < 6; j++) send_block(1'($urandom_range(0, 1)), rand64(), rand64());
		join
		in_valid <= 0;
		drain();
		n = 0;
		phase = 0;
		while (n < 1900) begin
			set_key((phase < 4) ? phase[1:0] : 2'($urandom_range(0, 3)));
			phase++;
			nb = $urandom_range(60, 160);
			for (int b = 0; b < nb && n < 1900; b++) begin
				burst = $urandom_range(1, 8);
				for (int j = 0; j < burst && n < 1900; j++) begin
					send_block(1'($urandom_range(0, 1)), rand64(), rand64());
					n++;
				end
				in_valid <= 0;
				if ($urandom_range(0, 1)) repeat ($urandom_range(1, 90)) @(negedge clk);
			end
			in_valid <= 0;
			drain();
		end
		if (fail_count == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+design
design/aes_pkg.sv
design/aes_key_mem.sv
design/aes_round.sv
design/aes_block_cipher.sv
design/aes_block_cipher_chk.sv
tb/aes_block_cipher_checker.sv
tb/tb_aes_block_cipher.sv
